// ----- rtl/row_to_all_euclidean_distance_unit_macros.svh -----
// Assertion macros shared by the distance unit RTL files.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef ROW_TO_ALL_EUCLIDEAN_DISTANCE_UNIT_MACROS_SVH
`define ROW_TO_ALL_EUCLIDEAN_DISTANCE_UNIT_MACROS_SVH

// Condition must never be true outside reset
`define EUCD_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define EUCD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define EUCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/eucd_pkg.sv -----
// Shared constants, payload types and inter-module structs of the distance unit.
// No dependencies; the top, front, queue and back end files import this package.
package eucd_pkg;

	// Store geometry
	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 16;
	localparam int DEPTH    = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W   = $clog2(DEPTH);

	// Field widths
	localparam int ROW_W     = 6;
	localparam int COL_W     = 4;
	localparam int VAL_W     = 16;
	localparam int DIST_W    = 18;
	localparam int NROW_W    = 7;
	localparam int NCOL_W    = 5;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_REF_ROW   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED = 2'd2;

	// Register reset values
	localparam logic [ROW_W-1:0]  REF_ROW_RST   = '0;
	localparam logic [NROW_W-1:0] ROWS_USED_RST = 7'd64;
	localparam logic [NCOL_W-1:0] COLS_USED_RST = 5'd16;

	// Arithmetic widths: difference 17 bits, square below 2^32
	localparam int DIFF_W = VAL_W + 1;
	localparam int SQ_W   = 32;
	localparam int SUM_W  = SQ_W + $clog2(MAX_COLS);
	localparam int ROOT_W = (SUM_W + 1) / 2;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 2;
	localparam int STEP_W = $clog2(ROOT_W);
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	// Reference row buffer: columns in use never exceed the column register range
	localparam int NCOL_MAX = (MAX_COLS < 31) ? MAX_COLS : 31;
	localparam int REF_IW   = (NCOL_MAX > 1) ? $clog2(NCOL_MAX) : 1;

	// Row-sum queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic [ROW_W-1:0]        elem_row;
		logic [COL_W-1:0]        elem_col;
		logic signed [VAL_W-1:0] elem_value;
		logic                    load_done;
	} elem_t;

	typedef struct packed {
		logic [ROW_W-1:0]  out_row;
		logic [DIST_W-1:0] distance;
		logic              last_of_run;
	} result_t;

	// One finished sum of squares, front to back
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [SUM_W-1:0] sum;
		logic             last;
	} row_sum_t;

	// Run settings, saturated, handed to the front at run start
	typedef struct packed {
		logic [ROW_W-1:0]  ref_row;
		logic              ref_ok;
		logic [NROW_W-1:0] nrows;
		logic [NCOL_W-1:0] ncols;
	} run_cfg_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              full;
		logic              empty;
	} queue_stat_t;

endpackage

// ----- rtl/row_to_all_euclidean_distance_unit.sv -----
// Top level of the row-to-all Euclidean distance unit: configuration registers,
// element store, front, queue and square-root back end.
// Depends on eucd_pkg, eucd_ram, eucd_front, eucd_queue, eucd_back and the macro header.
//
// Each start while busy is low transfers one Q8.8 element into the store, so a load
// runs at one element per clock. The element marked load_done starts a run. busy stays
// high from the next cycle until the cycle that carries the last result. A run with no
// rows in use gives no result and leaves busy low. A run first reads the reference row,
// one store entry for each of the C columns in use (at least one). The front then reads
// one store entry per cycle through the single read port, while the queue has room for
// each new row. Each sum then goes through a square root of one digit per cycle, and the
// back end takes the next sum only once it is done with the last. C never exceeds 16, so
// the root sets the pace, and results appear in row order. Each result is on result for
// exactly one cycle with result_valid high. The receiver cannot hold results off. The
// next start can be taken in the cycle that carries the last result of a run.
// Configuration writes belong in idle periods only.
`include "row_to_all_euclidean_distance_unit_macros.svh"

module row_to_all_euclidean_distance_unit import eucd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  elem_t                item,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output result_t              result,
	output logic                 result_valid
);

	logic [ROW_W-1:0]  ref_row_q;
	logic [NROW_W-1:0] rows_used_q;
	logic [NCOL_W-1:0] cols_used_q;

	logic              accept;
	logic              in_store;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic [VAL_W-1:0]  rdata;
	run_cfg_t          run_cfg;
	logic              front_active;
	logic              push, pop;
	row_sum_t          push_data, pop_data;
	queue_stat_t       qstat;
	logic              back_busy;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_row_q   <= REF_ROW_RST;
			rows_used_q <= ROWS_USED_RST;
			cols_used_q <= COLS_USED_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_REF_ROW:   ref_row_q   <= cfg_data[ROW_W-1:0];
				CFG_ROWS_USED: rows_used_q <= cfg_data[NROW_W-1:0];
				CFG_COLS_USED: cols_used_q <= cfg_data[NCOL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Saturate run settings to the store geometry
	always_comb begin
		run_cfg.ref_row = ref_row_q;
		run_cfg.ref_ok  = (int'(ref_row_q) < MAX_ROWS);
		run_cfg.nrows   = (int'(rows_used_q) > MAX_ROWS) ? NROW_W'(MAX_ROWS) : rows_used_q;
		run_cfg.ncols   = (int'(cols_used_q) > MAX_COLS) ? NCOL_W'(MAX_COLS) : cols_used_q;
	end

	// Input transfer writes the store; elements outside it are dropped
	assign accept   = start && !busy;
	assign in_store = (int'(item.elem_row) < MAX_ROWS) && (int'(item.elem_col) < MAX_COLS);
	assign waddr    = ADDR_W'(int'(item.elem_row) * MAX_COLS + int'(item.elem_col));

	eucd_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (accept && in_store),
		.waddr(waddr),
		.wdata(item.elem_value),
		.raddr(raddr),
		.rdata(rdata)
	);

	eucd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start_run(accept && item.load_done),
		.run_cfg  (run_cfg),
		.qstat    (qstat),
		.ram_raddr(raddr),
		.ram_rdata(rdata),
		.push     (push),
		.push_data(push_data),
		.active   (front_active)
	);

	eucd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.stat     (qstat)
	);

	eucd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.qstat       (qstat),
		.pop_data    (pop_data),
		.pop         (pop),
		.result      (result),
		.result_valid(result_valid),
		.busy        (back_busy)
	);

	assign busy = front_active || !qstat.empty || back_busy;

	`EUCD_ASSERT_NEVER(a_last_ends_run, result_valid && result.last_of_run && busy,
		"top: work left after the last result of a run")
	`EUCD_ASSERT_IMPL(a_result_needs_run, result_valid, $past(busy),
		"top: result strobe without a run in progress")

endmodule

// ----- rtl/eucd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module eucd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/eucd_front.sv -----
// Front of the distance unit: reads the reference row and each row from the store,
// squares column differences and accumulates one sum per row into the queue.
// Depends on eucd_pkg and the assertion macro header.
`include "row_to_all_euclidean_distance_unit_macros.svh"

module eucd_front import eucd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start_run,
	input  run_cfg_t          run_cfg,
	input  queue_stat_t       qstat,
	output logic [ADDR_W-1:0] ram_raddr,
	input  logic [VAL_W-1:0]  ram_rdata,
	output logic              push,
	output row_sum_t          push_data,
	output logic              active
);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_REF  = 3'b010,
		F_ROW  = 3'b100
	} front_state_t;

	front_state_t state_q;

	// Run settings latched at start
	logic [ROW_W-1:0]  ref_q;
	logic              ref_ok_q;
	logic [NROW_W-1:0] nrows_q;
	logic [NCOL_W-1:0] last_col_q;
	logic              zero_cols_q;

	logic [NCOL_W-1:0] col_q;
	logic [ROW_W-1:0]  row_q;
	logic [1:0]        pend_q;

	logic [VAL_W-1:0]  ref_buf_q [NCOL_MAX];

	// Read tag, stage 1 (data from store valid)
	logic              v_s1, rf_s1;
	logic [NCOL_W-1:0] col_s1;
	logic              first_s1, last_s1, mask_s1, lrow_s1;
	logic [ROW_W-1:0]  row_s1;

	// Square, stage 2
	logic              v_s2, first_s2, last_s2, lrow_s2;
	logic [ROW_W-1:0]  row_s2;
	logic [SQ_W-1:0]   sq_s2;
	logic [SUM_W-1:0]  acc_q;

	logic              credit_ok;
	logic              issue;
	logic              row_start;
	logic              col_last;
	logic              row_last;
	logic [ROW_W-1:0]  rd_row;
	logic [VAL_W-1:0]  ref_val;
	logic signed [DIFF_W-1:0]   diff;
	logic signed [2*DIFF_W-1:0] sq_full;
	logic [SUM_W-1:0]  sum;

	// Issue control: a new row needs a free queue slot counting rows in flight
	assign credit_ok = ({1'b0, qstat.count} + {{(QCNT_W - 1){1'b0}}, pend_q})
		< (QCNT_W + 1)'(Q_DEPTH);
	assign col_last  = (col_q == last_col_q);
	assign row_last  = ({1'b0, row_q} == (nrows_q - NROW_W'(1)));
	assign issue     = (state_q == F_REF) ||
		((state_q == F_ROW) && ((col_q != '0) || credit_ok));
	assign row_start = issue && (state_q == F_ROW) && (col_q == '0);
	assign rd_row    = (state_q == F_REF) ? ref_q : row_q;
	assign ram_raddr = ADDR_W'(int'(rd_row) * MAX_COLS + int'(col_q));

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					col_q <= '0;
					row_q <= '0;
					if (start_run && (run_cfg.nrows != '0)) begin
						state_q <= F_REF;
					end
				end
				F_REF: begin
					if (col_last) begin
						col_q   <= '0;
						state_q <= F_ROW;
					end else begin
						col_q <= col_q + NCOL_W'(1);
					end
				end
				F_ROW: begin
					if (issue) begin
						if (col_last) begin
							col_q <= '0;
							if (row_last) begin
								state_q <= F_IDLE;
							end else begin
								row_q <= row_q + ROW_W'(1);
							end
						end else begin
							col_q <= col_q + NCOL_W'(1);
						end
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	// Latch run settings; zero columns still run one masked read per row
	always_ff @(posedge clk) begin
		if ((state_q == F_IDLE) && start_run) begin
			ref_q       <= run_cfg.ref_row;
			ref_ok_q    <= run_cfg.ref_ok;
			nrows_q     <= run_cfg.nrows;
			zero_cols_q <= (run_cfg.ncols == '0);
			last_col_q  <= (run_cfg.ncols == '0) ? '0 : (run_cfg.ncols - NCOL_W'(1));
		end
	end

	// Rows started but not yet pushed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, row_start} - {1'b0, push};
		end
	end

	// Stage 1 tag control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			rf_s1 <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			v_s1  <= issue && (state_q == F_ROW);
			rf_s1 <= (state_q == F_REF);
			v_s2  <= v_s1;
		end
	end

	// Stage 1 tag payload
	always_ff @(posedge clk) begin
		col_s1   <= col_q;
		first_s1 <= (col_q == '0);
		last_s1  <= col_last;
		mask_s1  <= zero_cols_q;
		row_s1   <= row_q;
		lrow_s1  <= row_last;
	end

	// Difference against the buffered reference and square
	assign ref_val = ref_buf_q[col_s1[REF_IW-1:0]];
	assign diff    = DIFF_W'(signed'(ram_rdata)) - DIFF_W'(signed'(ref_val));
	assign sq_full = diff * diff;

	// Capture reference entries; out-of-store reference reads as zero
	always_ff @(posedge clk) begin
		if (rf_s1) begin
			ref_buf_q[col_s1[REF_IW-1:0]] <= ref_ok_q ? ram_rdata : '0;
		end
	end

	// Stage 2 payload
	always_ff @(posedge clk) begin
		sq_s2    <= mask_s1 ? '0 : sq_full[SQ_W-1:0];
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		row_s2   <= row_s1;
		lrow_s2  <= lrow_s1;
	end

	// Accumulate across columns, push on the last column of a row
	assign sum = (first_s2 ? '0 : acc_q) + SUM_W'(sq_s2);

	always_ff @(posedge clk) begin
		if (v_s2) begin
			acc_q <= sum;
		end
	end

	assign push           = v_s2 && last_s2;
	assign push_data.row  = row_s2;
	assign push_data.sum  = sum;
	assign push_data.last = lrow_s2;
	assign active         = (state_q != F_IDLE) || (pend_q != '0);

	`EUCD_ASSERT_NEVER(a_credit_bound,
		({1'b0, qstat.count} + {{(QCNT_W - 1){1'b0}}, pend_q}) > (QCNT_W + 1)'(Q_DEPTH),
		"front: rows in flight exceed queue space")
	`EUCD_ASSERT_IMPL(a_push_has_pending, push, pend_q != '0,
		"front: row pushed without being started")

endmodule

// ----- rtl/eucd_queue.sv -----
// Short queue of row sums between the front and the square-root back end.
// Depends on eucd_pkg and the assertion macro header.
`include "row_to_all_euclidean_distance_unit_macros.svh"

module eucd_queue import eucd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  row_sum_t    push_data,
	input  logic        pop,
	output row_sum_t    pop_data,
	output queue_stat_t stat
);

	row_sum_t          slot_q [Q_DEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QCNT_W-1:0] count_q;

	// Store transfers into the queue
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (int'(wptr_q) == Q_DEPTH - 1) ? '0 : wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= (int'(rptr_q) == Q_DEPTH - 1) ? '0 : rptr_q + QPTR_W'(1);
			end
			count_q <= count_q + {{(QCNT_W - 1){1'b0}}, push} - {{(QCNT_W - 1){1'b0}}, pop};
		end
	end

	assign pop_data   = slot_q[rptr_q];
	assign stat.count = count_q;
	assign stat.full  = (count_q == QCNT_W'(Q_DEPTH));
	assign stat.empty = (count_q == '0);

	`EUCD_ASSERT_NEVER(a_no_overflow, push && stat.full && !pop,
		"queue: transfer into a full queue")
	`EUCD_ASSERT_NEVER(a_no_underflow, pop && stat.empty,
		"queue: pop from an empty queue")

endmodule

// ----- rtl/eucd_back.sv -----
// Back end of the distance unit: digit-by-digit integer square root of each
// row sum, two radicand bits per cycle, then a one-cycle result strobe.
// Depends on eucd_pkg and the assertion macro header.
`include "row_to_all_euclidean_distance_unit_macros.svh"

module eucd_back import eucd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  queue_stat_t qstat,
	input  row_sum_t    pop_data,
	output logic        pop,
	output result_t     result,
	output logic        result_valid,
	output logic        busy
);

	logic              busy_q;
	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [STEP_W-1:0] step_q;
	logic [ROW_W-1:0]  row_q;
	logic              last_q;
	result_t           result_q;
	logic              valid_q;

	logic [REM_W+1:0]  cand;
	logic [REM_W+1:0]  trial;
	logic              ge;
	logic [REM_W-1:0]  rem_n;
	logic [ROOT_W-1:0] root_n;
	logic [DIST_W-1:0] dist_n;
	logic              final_step;

	assign pop = !busy_q && !qstat.empty;

	// One root digit per cycle
	assign cand   = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial  = (REM_W + 2)'({root_q, 2'b01});
	assign ge     = (cand >= trial);
	assign rem_n  = ge ? REM_W'(cand - trial) : REM_W'(cand);
	assign root_n = {root_q[ROOT_W-2:0], ge};
	assign dist_n = (32'(root_n) > 32'(DIST_MAX)) ? DIST_MAX : DIST_W'(root_n);
	assign final_step = (step_q == STEP_W'(ROOT_W - 1));

	// Control: take a sum, iterate, drop busy on the last digit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= busy_q && final_step;
			if (pop) begin
				busy_q <= 1'b1;
			end else if (busy_q && final_step) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (pop) begin
			rad_q  <= RAD_W'(pop_data.sum);
			rem_q  <= '0;
			root_q <= '0;
			step_q <= '0;
			row_q  <= pop_data.row;
			last_q <= pop_data.last;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= rem_n;
			root_q <= root_n;
			step_q <= step_q + STEP_W'(1);
		end
		if (busy_q && final_step) begin
			result_q.out_row     <= row_q;
			result_q.distance    <= dist_n;
			result_q.last_of_run <= last_q;
		end
	end

	assign result       = result_q;
	assign result_valid = valid_q;
	assign busy         = busy_q;

	`EUCD_ASSERT_NEXT(a_strobe_single, result_valid, !result_valid,
		"back: result strobe on two consecutive cycles")

endmodule
